// ----- rtl/core/swd_pkg.sv -----
// ============================================================================
// swd_pkg
// Shared types and constants for the stack with duplicate removal.
// ============================================================================
`default_nettype none

package swd_pkg;

  // Fixed field widths of the request and reply beats
  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 8;
  localparam int FILL_W   = 9;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_DEDUP = 2'd3
  } req_t;

  // Entry store port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/swd_ram.sv -----
// ============================================================================
// swd_ram
// Entry store: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module swd_ram #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 32
) (
  input  wire logic                     clk,
  input  wire swd_pkg::ram_ctl_t        ctl,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);
  import swd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write and read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/stack_with_dedup.sv -----
// ============================================================================
// stack_with_dedup
// Bounded LIFO stack of signed words with push, pop, peek and duplicate
// removal. Entries live in one synchronous RAM; a sequencer walks it.
// ============================================================================
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+----------
//  in      | input     | in_req_type, in_push_value, in_depth_index | in_valid/in_ready
//  out     | output    | out_read_value, out_ok, out_fill_level  | out_valid/out_ready
//
//  Push, pop and peek pass from the accept cycle to S_RESP, where the reply
//  register loads once it is free; the RAM read for pop and peek is issued
//  in the accept cycle. A new beat is not taken until the last reply is
//  posted. Dedup, for each entry, does one RAM read of it, then one read per
//  later entry until a match or the end, all through the single RAM read port.
//  Reset clears the fill count, sequencer and reply valid; RAM is not cleared.
//  A stalled reply holds in the output register while the next beat is
//  accepted; the one after it waits until the reply is taken.
// ============================================================================
`default_nettype none

module stack_with_dedup #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [swd_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic signed [swd_pkg::VALUE_W-1:0]  in_push_value,
  input  wire logic        [swd_pkg::IDX_W-1:0]    in_depth_index,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [swd_pkg::VALUE_W-1:0]  out_read_value,
  output logic                                     out_ok,
  output logic             [swd_pkg::FILL_W-1:0]   out_fill_level
);
  import swd_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DJ,     // holds the candidate entry just read
    S_DK,     // compares the candidate against a later entry
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]      w_r, w_nxt;
  logic [DATA_W-1:0]     val_r, val_nxt;
  logic                  ok_r, ok_nxt;
  logic                  take_r, take_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [FILL_W-1:0]     out_fill_r, out_fill_nxt;

  ram_ctl_t              ram_ctl;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_W-1:0]     wr_data;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DATA_W-1:0]     rd_data;

  logic [63:0]           push_sx;
  logic [DATA_W-1:0]     push_store;
  logic signed [DATA_W-1:0] rd_signed;
  logic [63:0]           rd_sx;
  logic                  peek_hit;
  logic [CMP_W-1:0]      peek_diff;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W-1:0]      j_inc;
  logic [CNT_W-1:0]      k_inc;
  logic [CNT_W-1:0]      w_new;
  logic                  adv;
  logic                  keep;
  logic [DATA_W-1:0]     keep_val;

  // Value conversion between port and storage width
  assign push_sx    = {{(64 - VALUE_W){in_push_value[VALUE_W-1]}}, in_push_value};
  assign push_store = push_sx[DATA_W-1:0];
  assign rd_signed  = rd_data;
  assign rd_sx      = 64'(rd_signed);

  // Request decode helpers
  assign peek_hit  = CMP_W'(in_depth_index) < CMP_W'(count_r);
  assign peek_diff = CMP_W'(count_r) - CMP_W'(in_depth_index) - CMP_W'(1);
  assign cnt_dec   = count_r - ONE_C;
  assign j_inc     = j_r + ONE_C;
  assign k_inc     = k_r + ONE_C;

  assign in_ready = (state_r == S_IDLE);

  swd_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    take_nxt      = take_r;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    out_fill_nxt  = out_fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_ctl       = '0;
    wr_addr       = count_r[ADDR_W-1:0];
    wr_data       = push_store;
    rd_addr       = '0;
    adv           = 1'b0;
    keep          = 1'b0;
    keep_val      = rd_data;
    w_new         = w_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESP;
          ok_nxt    = 1'b0;
          take_nxt  = 1'b0;
          case (req_t'(in_req_type))
            REQ_PUSH: begin
              if (count_r != DEPTH_C) begin
                ram_ctl.wr_en = 1'b1;
                count_nxt     = count_r + ONE_C;
                ok_nxt        = 1'b1;
              end
            end
            REQ_POP: begin
              if (count_r != '0) begin
                ram_ctl.rd_en = 1'b1;
                rd_addr       = cnt_dec[ADDR_W-1:0];
                count_nxt     = cnt_dec;
                ok_nxt        = 1'b1;
                take_nxt      = 1'b1;
              end
            end
            REQ_PEEK: begin
              if (peek_hit) begin
                ram_ctl.rd_en = 1'b1;
                rd_addr       = peek_diff[ADDR_W-1:0];
                ok_nxt        = 1'b1;
                take_nxt      = 1'b1;
              end
            end
            REQ_DEDUP: begin
              ok_nxt = 1'b1;
              n_nxt  = count_r;
              j_nxt  = '0;
              w_nxt  = '0;
              if (count_r != '0) begin
                ram_ctl.rd_en = 1'b1;
                rd_addr       = '0;
                state_nxt     = S_DJ;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // Candidate arrives; scan later entries or keep it if it is the top
      S_DJ: begin
        val_nxt = rd_data;
        if (j_inc == n_r) begin
          adv      = 1'b1;
          keep     = 1'b1;
          keep_val = rd_data;
        end else begin
          ram_ctl.rd_en = 1'b1;
          rd_addr       = j_inc[ADDR_W-1:0];
          k_nxt         = j_inc;
          state_nxt     = S_DK;
        end
      end

      // Drop the candidate on a match; keep it once the scan runs out
      S_DK: begin
        if (rd_data == val_r) begin
          adv = 1'b1;
        end else if (k_inc == n_r) begin
          adv      = 1'b1;
          keep     = 1'b1;
          keep_val = val_r;
        end else begin
          ram_ctl.rd_en = 1'b1;
          rd_addr       = k_inc[ADDR_W-1:0];
          k_nxt         = k_inc;
        end
      end

      // Post the reply once the output register is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_value_nxt = take_r ? rd_sx[VALUE_W-1:0] : '0;
          out_fill_nxt  = FILL_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Compact a surviving entry and advance to the next candidate
    if (adv) begin
      if (keep) begin
        ram_ctl.wr_en = 1'b1;
        wr_addr       = w_r[ADDR_W-1:0];
        wr_data       = keep_val;
        w_new         = w_r + ONE_C;
      end
      w_nxt = w_new;
      j_nxt = j_inc;
      if (j_inc == n_r) begin
        count_nxt = w_new;
        state_nxt = S_RESP;
      end else begin
        ram_ctl.rd_en = 1'b1;
        rd_addr       = j_inc[ADDR_W-1:0];
        state_nxt     = S_DJ;
      end
    end
  end

  // Hold state, counters and reply register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    w_r         <= w_nxt;
    val_r       <= val_nxt;
    ok_r        <= ok_nxt;
    take_r      <= take_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
    out_fill_r  <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_ok         = out_ok_r;
  assign out_fill_level = out_fill_r;

`ifndef SYNTH
  // Fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("fill count above depth");

  // A push into a non-full stack grows it by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_PUSH && count_r != DEPTH_C)
    |=> count_r == $past(count_r) + ONE_C)
    else $error("push did not grow the stack");

  // Compaction write pointer never overtakes the candidate
  a_w_behind_j: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DJ || state_r == S_DK) |-> (w_r <= j_r && j_r < n_r))
    else $error("dedup pointers out of order");

  // Scan pointer stays above the candidate and inside the stack
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DK) |-> (k_r > j_r && k_r < n_r))
    else $error("dedup scan pointer out of range");
`endif

endmodule

`default_nettype wire

// ----- test/swd_reply_checker.sv -----
// ============================================================================
// swd_reply_checker
// Watches the request and reply channels of stack_with_dedup, keeps its own
// copy of the stack, predicts each reply and compares it field by field.
// ============================================================================

module swd_reply_checker #(
  parameter int DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [swd_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [swd_pkg::VALUE_W-1:0] in_push_value,
  input  logic [swd_pkg::IDX_W-1:0]          in_depth_index,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [swd_pkg::VALUE_W-1:0] out_read_value,
  input  logic                               out_ok,
  input  logic [swd_pkg::FILL_W-1:0]         out_fill_level,
  output int                                 error_count,
  output int                                 pending_replies
);
  import swd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic                      ok;
    logic [FILL_W-1:0]         fill_level;
  } reply_t;

  // Shadow stack and the replies still owed by the block
  logic [VALUE_W-1:0] stack_words [DEPTH];
  int unsigned        stack_fill;
  reply_t             owed_replies [$];

  // Keep only the copy of each value nearest the top, survivors in order
  function automatic void remove_duplicates();
    bit          drop_mark [DEPTH];
    int unsigned kept;
    kept = 0;
    for (int i = 0; i < DEPTH; i++) drop_mark[i] = 1'b0;
    for (int k = int'(stack_fill) - 1; k >= 0; k--) begin
      if (!drop_mark[k]) begin
        for (int j = 0; j < k; j++) begin
          if (stack_words[j] == stack_words[k]) drop_mark[j] = 1'b1;
        end
      end
    end
    for (int i = 0; i < int'(stack_fill); i++) begin
      if (!drop_mark[i]) begin
        stack_words[kept] = stack_words[i];
        kept++;
      end
    end
    stack_fill = kept;
  endfunction

  // Apply one request beat to the shadow stack and return its reply
  function automatic reply_t stack_reply(req_t kind, logic [VALUE_W-1:0] value,
                                         logic [IDX_W-1:0] idx);
    reply_t r;
    r.read_value = '0;
    r.ok         = 1'b0;
    case (kind)
      REQ_PUSH: begin
        if (stack_fill < DEPTH) begin
          stack_words[stack_fill] = value;
          stack_fill++;
          r.ok = 1'b1;
        end
      end
      REQ_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          r.read_value = stack_words[stack_fill];
          r.ok         = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (idx < stack_fill) begin
          r.read_value = stack_words[stack_fill - 1 - idx];
          r.ok         = 1'b1;
        end
      end
      default: begin
        remove_duplicates();
        r.ok = 1'b1;
      end
    endcase
    r.fill_level = stack_fill[FILL_W-1:0];
    return r;
  endfunction

  // Count and report a bad field
  function automatic void flag_field(string field, logic signed [VALUE_W-1:0] want,
                                     logic signed [VALUE_W-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  // Predict on each request beat, compare on each reply beat
  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      stack_fill = 0;
      owed_replies.delete();
    end else begin
      if (in_valid && in_ready) begin
        owed_replies.push_back(stack_reply(req_t'(in_req_type), in_push_value,
                                           in_depth_index));
      end
      if (out_valid && out_ready) begin
        got.read_value = out_read_value;
        got.ok         = out_ok;
        got.fill_level = out_fill_level;
        if (owed_replies.size() == 0) begin
          error_count++;
          $display("%0t: reply beat with none expected, got value %0d ok %0b fill %0d",
                   $time, got.read_value, got.ok, got.fill_level);
        end else begin
          want = owed_replies.pop_front();
          if (got.read_value !== want.read_value)
            flag_field("read_value", want.read_value, got.read_value);
          if (got.ok !== want.ok)
            flag_field("ok", VALUE_W'(want.ok), VALUE_W'(got.ok));
          if (got.fill_level !== want.fill_level)
            flag_field("fill_level", VALUE_W'(want.fill_level), VALUE_W'(got.fill_level));
        end
      end
    end
    pending_replies <= owed_replies.size();
  end

endmodule

// ----- test/tb_stack_with_dedup.sv -----
// ============================================================================
// tb_stack_with_dedup
// Drives push, pop, peek and dedup requests into stack_with_dedup with random
// gaps and reply stalls; the checker beside the block predicts and compares.
// ============================================================================

module tb_stack_with_dedup;
  import swd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 256;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [REQ_W-1:0]          in_req_type;
  logic signed [VALUE_W-1:0] in_push_value;
  logic [IDX_W-1:0]          in_depth_index;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] out_read_value;
  logic                      out_ok;
  logic [FILL_W-1:0]         out_fill_level;
  int                        error_count;
  int                        pending_replies;

  // Small set of values so that pushes repeat and dedup has work to do
  logic signed [VALUE_W-1:0] value_pool [16];
  bit                        in_steady;

  stack_with_dedup u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_push_value  (in_push_value),
    .in_depth_index (in_depth_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_ok         (out_ok),
    .out_fill_level (out_fill_level)
  );

  swd_reply_checker #(.DEPTH(STACK_DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .in_depth_index  (in_depth_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_ok          (out_ok),
    .out_fill_level  (out_fill_level),
    .error_count     (error_count),
    .pending_replies (pending_replies)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the reply channel: mostly short stalls, a few long, steady stretches
  initial begin : reply_stalls
    int  stall;
    bit  steady;
    stall     = 0;
    steady    = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(199) == 0) steady = !steady;
        if (!steady && $urandom_range(4) == 0) begin
          stall = ($urandom_range(9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        end
      end
    end
  end

  // Send one request beat after a random gap; return at the accepting edge
  task automatic send_req(input req_t kind, input logic signed [VALUE_W-1:0] value,
                          input logic [IDX_W-1:0] idx);
    int gap;
    int roll;
    if ($urandom_range(99) == 0) in_steady = !in_steady;
    roll = $urandom_range(99);
    if (in_steady || roll < 50) gap = 0;
    else if (roll < 90)         gap = $urandom_range(1, 3);
    else                        gap = $urandom_range(8, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_valid       <= 1'b0;
      in_req_type    <= REQ_W'($urandom);
      in_push_value  <= $urandom;
      in_depth_index <= IDX_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_push_value  <= value;
    in_depth_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed reply has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies != 0) @(negedge clk);
  endtask

  // Random request mix with a small stack most of the time
  task automatic random_mix(input int count);
    req_t                      kind;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          idx;
    int                        roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35)      kind = REQ_PUSH;
      else if (roll < 65) kind = REQ_POP;
      else if (roll < 90) kind = REQ_PEEK;
      else                kind = REQ_DEDUP;
      value = ($urandom_range(99) < 55) ? value_pool[$urandom_range(15)] : $urandom;
      idx   = ($urandom_range(99) < 70) ? IDX_W'($urandom_range(0, 24))
                                        : IDX_W'($urandom_range(0, 255));
      send_req(kind, value, idx);
    end
  endtask

  // Fill to the top, push into a full stack, read the bottom, then dedup
  task automatic fill_to_full();
    repeat (STACK_DEPTH + 2) send_req(REQ_PUSH, value_pool[$urandom_range(15)], 8'd0);
    send_req(REQ_PEEK, $urandom, 8'd255);
    send_req(REQ_PEEK, $urandom, 8'd0);
    send_req(REQ_POP, $urandom, 8'd0);
    send_req(REQ_PEEK, $urandom, 8'd255);
    send_req(REQ_PUSH, value_pool[0], 8'd0);
    send_req(REQ_DEDUP, $urandom, 8'd0);
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_PUSH;
    in_push_value  = '0;
    in_depth_index = '0;
    in_steady      = 1'b0;
    value_pool[0]  = 32'sh8000_0000;
    value_pool[1]  = 32'sh7FFF_FFFF;
    value_pool[2]  = 32'sh0000_0000;
    value_pool[3]  = -32'sd1;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty stack: refused pop and peek, dedup still succeeds
    send_req(REQ_POP, 32'sd5, 8'd0);
    send_req(REQ_PEEK, 32'sd0, 8'd0);
    send_req(REQ_DEDUP, 32'sd0, 8'd0);
    // Extremes of the value, with a repeat of the bottom entry on top
    send_req(REQ_PUSH, 32'sh8000_0000, 8'd0);
    send_req(REQ_PUSH, 32'sh7FFF_FFFF, 8'd0);
    send_req(REQ_PUSH, 32'sh0000_0000, 8'd0);
    send_req(REQ_PUSH, -32'sd1, 8'd0);
    send_req(REQ_PUSH, 32'sh8000_0000, 8'd0);
    // Peek at top, bottom, one past the bottom and the largest index
    send_req(REQ_PEEK, 32'sd0, 8'd0);
    send_req(REQ_PEEK, 32'sd0, 8'd4);
    send_req(REQ_PEEK, 32'sd0, 8'd5);
    send_req(REQ_PEEK, 32'sd0, 8'd255);
    send_req(REQ_DEDUP, 32'sd0, 8'd0);
    send_req(REQ_PEEK, 32'sd0, 8'd3);
    send_req(REQ_POP, 32'sd0, 8'd0);
    send_req(REQ_PUSH, 32'sh7FFF_FFFF, 8'd0);
    send_req(REQ_PUSH, 32'sh7FFF_FFFF, 8'd0);
    send_req(REQ_DEDUP, 32'sd0, 8'd0);
    // Drain past empty
    repeat (4) send_req(REQ_POP, 32'sd0, 8'd0);

    wait_for_drain();
    random_mix(300);
    fill_to_full();
    random_mix(220);
    wait_for_drain();
    random_mix(100);
    wait_for_drain();
    repeat (50) @(negedge clk);

    if (error_count == 0 && pending_replies == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up on a hung block
  initial begin : watchdog
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
